// ===== src/wlpe_pkg.sv =====
// Shared types and constants for the WAV LSB payload extractor.
package wlpe_pkg;

	// Chunk id of the sample data chunk ("data", little endian)
	localparam logic [31:0] DATA_ID = 32'h6174_6164;
	localparam int RIFF_HDR_BYTES = 12;
	localparam int LEN_BYTES = 8;

	// Result queue depth and derived widths
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	// Status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_SHORT     = 3'd1;
	localparam status_t ST_NO_DATA   = 3'd2;
	localparam status_t ST_BEYOND    = 3'd3;
	localparam status_t ST_HDR_LARGE = 3'd4;
	localparam status_t ST_OOB       = 3'd5;
	localparam status_t ST_CORRUPT   = 3'd6;

	// Field kinds of recovered header bytes
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_NAME_LEN = 2'd0;
	localparam kind_t KIND_NAME     = 2'd1;
	localparam kind_t KIND_SEC_SIZE = 2'd2;
	localparam kind_t KIND_SECRET   = 2'd3;

	// Parser phase
	typedef enum logic [6:0] {
		PH_RIFF  = 7'b0000001,
		PH_CHDR  = 7'b0000010,
		PH_SKIP  = 7'b0000100,
		PH_LEN   = 7'b0001000,
		PH_HDR   = 7'b0010000,
		PH_DRAIN = 7'b0100000,
		PH_DONE  = 7'b1000000
	} phase_t;

	// One result word
	typedef struct packed {
		logic [7:0] payload_byte;
		kind_t      field_kind;
		logic       is_status;
		status_t    status;
		logic       last;
	} result_t;

endpackage

// ===== src/wlpe_out_fifo.sv =====
// Result queue: takes up to two result words per cycle, gives one per cycle when popped.
module wlpe_out_fifo
	import wlpe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  result_t             wr_a,
	input  result_t             wr_b,
	input  logic                pop,
	output result_t             head,
	output logic [FIFO_CW-1:0]  count
);

	result_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic [FIFO_AW-1:0] wr_ptr_b;

	assign wr_ptr_b = wr_ptr_q + FIFO_AW'(1);
	assign head = mem_q[rd_ptr_q];
	assign count = cnt_q;

	// Storage: first word, then the second when two arrive together
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= wr_a;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_b] <= wr_b;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
		end
	end

endmodule

// ===== src/wav_lsb_payload_extractor_top.sv =====
// WAV LSB payload extractor: chunk walker, LSB byte assembler and result queue.
// Output: a result word is written into the result queue when its file byte is taken, and offered from its head.
// Throughput: one file byte per cycle; a byte yields at most two words (header byte
// plus final status), queued in a four-word result queue that stalls input when nearly full.
// Reset: arst_n clears the parser to the start of a file and empties the queue.
// Each end_of_file byte also returns the parser to the start of a new file.
module wav_lsb_payload_extractor_top
	import wlpe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] wav_byte,
	input  logic       end_of_file,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic [1:0] field_kind,
	output logic       is_status,
	output logic [2:0] status,
	output logic       last
);

	// Header field check: L >= 4, 12 + N <= L, S <= L - 12 - N
	function automatic status_t check_fields(logic [31:0] l, logic [31:0] n, logic [63:0] s);
		logic [32:0] fixed;
		logic [32:0] rem;
		status_t r;
		fixed = {1'b0, n} + 33'd12;
		rem = {1'b0, l} - fixed;
		r = ST_OK;
		if (l < 32'd4) begin
			r = ST_CORRUPT;
		end else if (fixed > {1'b0, l}) begin
			r = ST_CORRUPT;
		end else if (s > {31'b0, rem}) begin
			r = ST_CORRUPT;
		end
		return r;
	endfunction

	// Parser state
	phase_t      phase_q, phase_d;
	logic [3:0]  riff_cnt_q, riff_cnt_d;
	logic [63:0] chunk_sh_q, chunk_sh_d;
	logic [31:0] skip_q, skip_d;
	logic [31:0] total_q, total_d;
	logic [31:0] left_q, left_d;
	logic [7:0]  asm_q, asm_d;
	logic [2:0]  bcnt_q, bcnt_d;
	logic [63:0] hlen_q, hlen_d;
	logic [31:0] hleft_q, hleft_d;
	logic [31:0] name_q, name_d;
	logic [63:0] sec_q, sec_d;
	logic [31:0] idx_q, idx_d;
	status_t     pend_q, pend_d;

	// Per-word results
	logic        by_valid;
	kind_t       by_kind;
	logic        st_valid;
	status_t     st_code;

	logic        accept;
	logic [63:0] sh_next;
	logic [7:0]  asm_next;
	logic [63:0] hlen_new;
	logic [33:0] nend;
	logic [33:0] send;
	logic [33:0] sec_off;
	logic [2:0]  sec_pos;

	result_t     res_a, res_b;
	logic [1:0]  push_cnt;
	result_t     head;
	logic [FIFO_CW-1:0] q_count;

	assign accept = in_valid && in_ready;
	assign in_ready = (q_count <= FIFO_CW'(FIFO_DEPTH - 2));

	assign sh_next = {wav_byte, chunk_sh_q[63:8]};
	assign asm_next = {asm_q[6:0], wav_byte[0]};
	assign hlen_new = hlen_q | ({56'b0, asm_next} << {idx_q[2:0], 3'b000});
	assign nend = {2'b0, name_q} + 34'd4;
	assign send = nend + 34'd8;
	assign sec_off = {2'b0, idx_q} - send;
	assign sec_pos = idx_q[2:0] - name_q[2:0] - 3'd4;

	// Next-state and result logic for one file byte
	always_comb begin
		phase_d = phase_q;
		riff_cnt_d = riff_cnt_q;
		chunk_sh_d = chunk_sh_q;
		skip_d = skip_q;
		total_d = total_q;
		left_d = left_q;
		asm_d = asm_q;
		bcnt_d = bcnt_q;
		hlen_d = hlen_q;
		hleft_d = hleft_q;
		name_d = name_q;
		sec_d = sec_q;
		idx_d = idx_q;
		pend_d = pend_q;
		by_valid = 1'b0;
		by_kind = KIND_NAME_LEN;
		st_valid = 1'b0;
		st_code = ST_OK;

		unique case (phase_q)
			PH_RIFF: begin
				riff_cnt_d = riff_cnt_q + 4'd1;
				if (riff_cnt_q == 4'(RIFF_HDR_BYTES - 1)) begin
					phase_d = PH_CHDR;
					skip_d = '0;
					chunk_sh_d = '0;
				end
			end
			PH_CHDR: begin
				chunk_sh_d = sh_next;
				skip_d = skip_q + 32'd1;
				if (skip_q == 32'd7) begin
					chunk_sh_d = '0;
					skip_d = '0;
					if (sh_next[31:0] == DATA_ID) begin
						total_d = sh_next[63:32];
						left_d = sh_next[63:32];
						asm_d = '0;
						bcnt_d = '0;
						idx_d = '0;
						hlen_d = '0;
						phase_d = PH_LEN;
						// Empty data chunk cannot hold the length field
						if (sh_next[63:32] == 32'd0) begin
							st_valid = 1'b1;
							st_code = ST_OOB;
							phase_d = PH_DONE;
						end
					end else if (sh_next[63:32] != 32'd0) begin
						skip_d = sh_next[63:32];
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - 32'd1;
				if (skip_q == 32'd1) begin
					phase_d = PH_CHDR;
				end
			end
			PH_LEN, PH_HDR, PH_DRAIN: begin
				left_d = left_q - 32'd1;
				if (phase_q != PH_DRAIN) begin
					asm_d = asm_next;
					bcnt_d = bcnt_q + 3'd1;
					if (bcnt_q == 3'd7) begin
						asm_d = '0;
						if (phase_q == PH_LEN) begin
							// Header length, little endian
							hlen_d = hlen_new;
							idx_d = idx_q + 32'd1;
							if (idx_q[2:0] == 3'(LEN_BYTES - 1)) begin
								idx_d = '0;
								if ((hlen_new[63:32] != 32'd0) || (hlen_new[31:0] > total_q)) begin
									pend_d = ST_HDR_LARGE;
									phase_d = PH_DRAIN;
								end else if (hlen_new == 64'd0) begin
									pend_d = ST_CORRUPT;
									phase_d = PH_DRAIN;
								end else begin
									hleft_d = hlen_new[31:0];
									phase_d = PH_HDR;
								end
							end
						end else begin
							// Header byte routing by position
							if (idx_q < 32'd4) begin
								name_d = name_q | ({24'b0, asm_next} << {idx_q[1:0], 3'b000});
								by_valid = 1'b1;
								by_kind = KIND_NAME_LEN;
							end else if ({2'b0, idx_q} < nend) begin
								by_valid = 1'b1;
								by_kind = KIND_NAME;
							end else if ({2'b0, idx_q} < send) begin
								sec_d = sec_q | ({56'b0, asm_next} << {sec_pos, 3'b000});
								by_valid = 1'b1;
								by_kind = KIND_SEC_SIZE;
							end else if ({30'b0, sec_off} < sec_q) begin
								by_valid = 1'b1;
								by_kind = KIND_SECRET;
							end
							idx_d = idx_q + 32'd1;
							hleft_d = hleft_q - 32'd1;
							if (hleft_q == 32'd1) begin
								pend_d = check_fields(hlen_q[31:0], name_d, sec_d);
								phase_d = PH_DRAIN;
							end
						end
					end
				end
				// Data chunk fully received
				if (left_q == 32'd1) begin
					st_valid = 1'b1;
					st_code = (phase_d == PH_DRAIN) ? pend_d : ST_OOB;
					phase_d = PH_DONE;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// End of file: report if still open, then restart
		if (end_of_file) begin
			unique case (phase_d)
				PH_RIFF: begin
					st_valid = 1'b1;
					st_code = ST_SHORT;
				end
				PH_CHDR, PH_SKIP: begin
					st_valid = 1'b1;
					st_code = ST_NO_DATA;
				end
				PH_LEN, PH_HDR, PH_DRAIN: begin
					st_valid = 1'b1;
					st_code = ST_BEYOND;
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
			phase_d = PH_RIFF;
			riff_cnt_d = '0;
			chunk_sh_d = '0;
			skip_d = '0;
			total_d = '0;
			left_d = '0;
			asm_d = '0;
			bcnt_d = '0;
			hlen_d = '0;
			hleft_d = '0;
			name_d = '0;
			sec_d = '0;
			idx_d = '0;
			pend_d = ST_OK;
		end
	end

	// Parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			riff_cnt_q <= '0;
			chunk_sh_q <= '0;
			skip_q <= '0;
			total_q <= '0;
			left_q <= '0;
			asm_q <= '0;
			bcnt_q <= '0;
			hlen_q <= '0;
			hleft_q <= '0;
			name_q <= '0;
			sec_q <= '0;
			idx_q <= '0;
			pend_q <= ST_OK;
		end else if (accept) begin
			phase_q <= phase_d;
			riff_cnt_q <= riff_cnt_d;
			chunk_sh_q <= chunk_sh_d;
			skip_q <= skip_d;
			total_q <= total_d;
			left_q <= left_d;
			asm_q <= asm_d;
			bcnt_q <= bcnt_d;
			hlen_q <= hlen_d;
			hleft_q <= hleft_d;
			name_q <= name_d;
			sec_q <= sec_d;
			idx_q <= idx_d;
			pend_q <= pend_d;
		end
	end

	// Pack up to two result words: header byte first, then status
	always_comb begin
		res_b = '0;
		res_b.is_status = 1'b1;
		res_b.status = st_code;
		res_b.last = 1'b1;
		if (by_valid) begin
			res_a = '0;
			res_a.payload_byte = asm_next;
			res_a.field_kind = by_kind;
		end else begin
			res_a = res_b;
		end
		push_cnt = 2'd0;
		if (accept) begin
			push_cnt = 2'(by_valid) + 2'(st_valid);
		end
	end

	wlpe_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.wr_a     (res_a),
		.wr_b     (res_b),
		.pop      (out_valid && out_ready),
		.head     (head),
		.count    (q_count)
	);

	assign out_valid = (q_count != '0);
	assign payload_byte = head.payload_byte;
	assign field_kind = head.field_kind;
	assign is_status = head.is_status;
	assign status = head.status;
	assign last = head.last;

endmodule
